// ===== src/strtoi_pkg.sv =====
// strtoi_pkg: shared types and character constants of the string to integer parser
// used by strtoi_mac, strtoi_core and string_to_integer_parser_unit; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package strtoi_pkg;

	localparam int VALUE_W  = 64;
	localparam int OFFSET_W = 16;
	localparam int RADIX_W  = 6;
	localparam int CH_W     = 8;

	localparam logic [CH_W-1:0] CH_NUL0   = 8'h30; // '0'
	localparam logic [CH_W-1:0] CH_NINE   = 8'h39; // '9'
	localparam logic [CH_W-1:0] CH_UP_A   = 8'h41; // 'A'
	localparam logic [CH_W-1:0] CH_UP_Z   = 8'h5A; // 'Z'
	localparam logic [CH_W-1:0] CH_LO_A   = 8'h61; // 'a'
	localparam logic [CH_W-1:0] CH_LO_Z   = 8'h7A; // 'z'
	localparam logic [CH_W-1:0] CH_LO_X   = 8'h78; // 'x'
	localparam logic [CH_W-1:0] CH_UP_X   = 8'h58; // 'X'
	localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D; // '-'
	localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B; // '+'
	localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

	localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;

	// digit value of an invalid character, above any 6-bit base
	localparam logic [RADIX_W:0] DIGIT_NONE = 7'd64;

	typedef struct packed {
		logic                       valid;
		logic signed [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0]        end_offset;
		logic                       range_error;
		logic                       any_digits;
	} result_t;

endpackage

`default_nettype wire

// ===== src/strtoi_mac.sv =====
// strtoi_mac: accumulator times base plus digit, with saturation at the signed limit
// uses strtoi_pkg for widths
`timescale 1ns / 1ps
`default_nettype none

module strtoi_mac (
	input  wire logic [strtoi_pkg::VALUE_W-1:0] acc,
	input  wire logic [strtoi_pkg::RADIX_W-1:0] base,
	input  wire logic [strtoi_pkg::RADIX_W-1:0] digit,
	input  wire logic                           negative,
	output logic      [strtoi_pkg::VALUE_W-1:0] acc_next,
	output logic                                over
);

	localparam int PROD_W = strtoi_pkg::VALUE_W + strtoi_pkg::RADIX_W + 1;

	logic [strtoi_pkg::RADIX_W-1:0] mult;
	logic [PROD_W-1:0]              prod;
	logic [strtoi_pkg::VALUE_W-1:0] limit;

	// base zero behaves as one
	assign mult  = (base == '0) ? strtoi_pkg::RADIX_W'(1) : base;
	assign limit = negative ? {1'b1, {(strtoi_pkg::VALUE_W-1){1'b0}}}
	                        : {1'b0, {(strtoi_pkg::VALUE_W-1){1'b1}}};

	// exact product compared with the limit
	assign prod = PROD_W'(acc) * PROD_W'(mult) + PROD_W'(digit);
	assign over = prod > PROD_W'(limit);
	assign acc_next = over ? limit : prod[strtoi_pkg::VALUE_W-1:0];

endmodule

`default_nettype wire

// ===== src/strtoi_core.sv =====
// strtoi_core: per-string parse state and the single-step character handling
// uses strtoi_pkg and strtoi_mac
`timescale 1ns / 1ps
`default_nettype none

module strtoi_core #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step_en,
	input  wire logic [strtoi_pkg::CH_W-1:0]    ch,
	input  wire logic                           start,
	input  wire logic [strtoi_pkg::RADIX_W-1:0] radix,
	output strtoi_pkg::result_t                 res
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_SPACE, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		DS_NONE, DS_SOME, DS_OVER
	} dstat_t;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	function automatic logic [strtoi_pkg::RADIX_W:0] digit_of(
		input logic [strtoi_pkg::CH_W-1:0] c
	);
		logic [strtoi_pkg::RADIX_W:0] d;
		if (c >= strtoi_pkg::CH_NUL0 && c <= strtoi_pkg::CH_NINE)
			d = 7'(c - strtoi_pkg::CH_NUL0);
		else if (c >= strtoi_pkg::CH_UP_A && c <= strtoi_pkg::CH_UP_Z)
			d = 7'(c - strtoi_pkg::CH_UP_A + 8'd10);
		else if (c >= strtoi_pkg::CH_LO_A && c <= strtoi_pkg::CH_LO_Z)
			d = 7'(c - strtoi_pkg::CH_LO_A + 8'd10);
		else
			d = strtoi_pkg::DIGIT_NONE;
		return d;
	endfunction

	phase_t                          phase_q, phase_e, phase_n;
	dstat_t                          ds_q, ds_e, ds_n;
	logic                            neg_q, neg_e, neg_n;
	logic [strtoi_pkg::RADIX_W-1:0]  base_q, base_e, base_n, base_dig;
	logic [strtoi_pkg::VALUE_W-1:0]  acc_q, acc_e, acc_n, mac_acc;
	logic [COUNT_WIDTH-1:0]          cnt_q, cnt_n;
	logic [31:0]                     cnt_ext;
	logic [strtoi_pkg::OFFSET_W-1:0] cnt_sat;
	logic [strtoi_pkg::RADIX_W:0]    dig;
	logic                            active, mac_over, is_space, auto_or_hex;
	logic                            do_digit;
	logic [strtoi_pkg::VALUE_W-1:0]  mag;

	assign active  = step_en && (start || phase_q != PH_IDLE);
	assign phase_e = start ? PH_SPACE : phase_q;
	assign ds_e    = start ? DS_NONE : ds_q;
	assign neg_e   = start ? 1'b0 : neg_q;
	assign base_e  = start ? radix : base_q;
	assign acc_e   = start ? '0 : acc_q;
	assign cnt_n   = start ? '0 : ((cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1);

	assign cnt_ext = 32'(cnt_n);
	assign cnt_sat = (|cnt_ext[31:16]) ? '1 : cnt_ext[15:0];

	assign dig         = digit_of(ch);
	assign is_space    = ch == strtoi_pkg::CH_SPACE
	                  || (ch >= strtoi_pkg::CH_TAB && ch <= strtoi_pkg::CH_CR);
	assign auto_or_hex = base_e == strtoi_pkg::BASE_AUTO || base_e == strtoi_pkg::BASE_HEX;

	// base that a digit in this step is checked against
	always_comb begin
		base_dig = base_e;
		if (base_e == strtoi_pkg::BASE_AUTO) begin
			if (phase_e == PH_ZERO)
				base_dig = strtoi_pkg::BASE_OCT;
			else if (phase_e == PH_SPACE || phase_e == PH_SIGNED)
				base_dig = strtoi_pkg::BASE_DEC;
		end
	end

	strtoi_mac u_mac (
		.acc      (acc_e),
		.base     (base_dig),
		.digit    (dig[strtoi_pkg::RADIX_W-1:0]),
		.negative (neg_e),
		.acc_next (mac_acc),
		.over     (mac_over)
	);

	always_comb begin
		phase_n  = phase_e;
		ds_n     = ds_e;
		neg_n    = neg_e;
		base_n   = base_e;
		acc_n    = acc_e;
		do_digit = 1'b0;
		res      = '0;
		mag      = '0;
		case (phase_e)
			PH_SPACE: begin
				if (is_space) begin
					phase_n = PH_SPACE;
				end else if (ch == strtoi_pkg::CH_MINUS) begin
					neg_n   = 1'b1;
					phase_n = PH_SIGNED;
				end else if (ch == strtoi_pkg::CH_PLUS) begin
					phase_n = PH_SIGNED;
				end else if (auto_or_hex && ch == strtoi_pkg::CH_NUL0) begin
					phase_n = PH_ZERO;
				end else begin
					base_n   = base_dig;
					do_digit = 1'b1;
				end
			end
			PH_SIGNED: begin
				if (auto_or_hex && ch == strtoi_pkg::CH_NUL0) begin
					phase_n = PH_ZERO;
				end else begin
					base_n   = base_dig;
					do_digit = 1'b1;
				end
			end
			PH_ZERO: begin
				if (ch == strtoi_pkg::CH_LO_X || ch == strtoi_pkg::CH_UP_X) begin
					base_n  = strtoi_pkg::BASE_HEX;
					phase_n = PH_PREFIX;
				end else begin
					// the leading zero counts as a digit, value stays zero
					base_n   = base_dig;
					ds_n     = DS_SOME;
					do_digit = 1'b1;
				end
			end
			PH_PREFIX, PH_DIGITS: begin
				do_digit = 1'b1;
			end
			PH_IDLE: begin
				phase_n = PH_IDLE;
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		if (do_digit) begin
			phase_n = PH_DIGITS;
			if (dig >= {1'b0, base_n}) begin
				mag              = (ds_n == DS_NONE) ? '0 : acc_n;
				res.valid        = active;
				res.value        = neg_n ? -mag : mag;
				res.end_offset   = (ds_n == DS_NONE) ? '0 : cnt_sat;
				res.range_error  = ds_n == DS_OVER;
				res.any_digits   = ds_n != DS_NONE;
				phase_n          = PH_IDLE;
			end else if (ds_n != DS_OVER) begin
				acc_n = mac_acc;
				ds_n  = mac_over ? DS_OVER : DS_SOME;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ds_q    <= DS_NONE;
			neg_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (active) begin
			phase_q <= phase_n;
			ds_q    <= ds_n;
			neg_q   <= neg_n;
			base_q  <= base_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/string_to_integer_parser_unit.sv =====
// string_to_integer_parser_unit: streaming characters in, one signed 64-bit result per string
// uses strtoi_pkg and strtoi_core
`timescale 1ns / 1ps
`default_nettype none

// Takes one character per transaction and sustains one character per clock while the output
// side keeps up. A character is held in an input register and handled by the parse step (a
// 64 by 6 bit multiply-add with a saturation compare, which sets the clock path) when it
// advances; the terminating character's result is then written to the output register.
// Input stalls whenever a character is held and the output register is full and not being
// taken, whether or not that character ends a string. The radix register resets to 16 and is
// sampled when a start mark is handled.
module string_to_integer_parser_unit #(
	parameter int COUNT_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [5:0]  cfg_wdata,  // radix
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // ch
	input  wire logic        s_tuser,    // start_req
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata     // value, end_offset, range_error, any_digits, zero pad
);

	localparam logic [strtoi_pkg::RADIX_W-1:0] RADIX_RESET = strtoi_pkg::BASE_HEX;

	logic [strtoi_pkg::RADIX_W-1:0] radix_q;
	logic                           valid_s1;
	logic [strtoi_pkg::CH_W-1:0]    ch_s1;
	logic                           start_s1;
	logic                           advance;
	strtoi_pkg::result_t            res;
	strtoi_pkg::result_t            out_q;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1    <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	strtoi_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.ch      (ch_s1),
		.start   (start_s1),
		.radix   (radix_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance && res.valid) begin
			out_q <= res;
		end else if (m_tready) begin
			out_q.valid <= 1'b0;
		end
	end

	assign m_tvalid = out_q.valid;
	assign m_tdata  = {6'd0, out_q.any_digits, out_q.range_error,
	                   out_q.end_offset, out_q.value};

endmodule

`default_nettype wire
